### rtl/sbf_pkg.sv
// ----------------------------------------------------------------------------
// sbf_pkg
// Request and operation codes, side-wall masks and the slot record that
// travels from the slot generator to the read-modify-write stage.
// ----------------------------------------------------------------------------
`default_nettype none

package sbf_pkg;

	// request codes
	localparam logic [2:0] REQ_BLIT   = 3'd0;
	localparam logic [2:0] REQ_PIX_WR = 3'd1;
	localparam logic [2:0] REQ_PIX_RD = 3'd2;
	localparam logic [2:0] REQ_CLEAR  = 3'd3;
	localparam logic [2:0] REQ_SCAN   = 3'd4;

	// operation codes
	localparam logic [2:0] OP_OR   = 3'd0;
	localparam logic [2:0] OP_XOR  = 3'd1;
	localparam logic [2:0] OP_SET  = 3'd2;
	localparam logic [2:0] OP_CLR  = 3'd3;
	localparam logic [2:0] OP_TEST = 3'd4;

	// extended side walls seen by rows above the top
	localparam logic [7:0] WALL_LEFT  = 8'b1000_0000;
	localparam logic [7:0] WALL_RIGHT = 8'b0001_0000;

	// leftmost pixel of a panel row
	localparam logic [7:0] PIX_MSB = 8'h80;

	// number of panel rows and blit part slots
	localparam int unsigned NUM_ROWS  = 32;
	localparam int unsigned BLIT_SLOTS = 16;

	// one unit of work for the memory stage
	typedef struct packed {
		logic       test;   // read the row and check it against part
		logic       wr;     // read the row, combine with part, write back
		logic       imm;    // collision decided without the frame
		logic       scan;   // read the row and send it to the driver side
		logic       last;   // final slot of the request
		logic [4:0] addr;   // panel*8 + row
		logic [7:0] part;
	} slot_t;

endpackage

`default_nettype wire

### rtl/sprite_blit_framebuffer.sv
// ----------------------------------------------------------------------------
// sprite_blit_framebuffer
// 16x16 one-bit frame in a 32x8 synchronous memory (four 8x8 panels). Blits,
// pixel writes and queries, frame clear and a 32-row scan-out to the drivers.
// ----------------------------------------------------------------------------
// Flow: a blit walks 16 part slots, one per cycle, through the memory
// read-modify-write to the result strobe, and a collision hit ends it early;
// a pixel write or query makes one slot; clear and unknown requests give
// their strobe in the cycle after accept; scan-out gives one row beat per
// cycle for 32 rows. One request at a time: busy holds through a blit, a
// pixel access or a scan-out and stays low for clear and unknown requests.
// Reset: the frame reads as cleared; the results need no acknowledgment.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_blit_framebuffer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output      logic               busy,
	input  wire logic [2:0]         req_type,
	input  wire logic [2:0]         op,
	input  wire logic signed [5:0]  x_pos,
	input  wire logic signed [5:0]  y_pos,
	input  wire logic [63:0]        sprite_bits,
	output      logic               strobe,
	output      logic               hit_bit,
	output      logic [1:0]         chip_index,
	output      logic [2:0]         chip_row,
	output      logic [7:0]         row_data,
	output      logic               last
);

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_WAIT = 2'd2;

	logic [1:0]         state_q;
	logic [4:0]         cnt_q;
	logic [2:0]         req_q;
	logic [2:0]         op_q;
	logic signed [5:0]  x_q;
	logic signed [5:0]  y_q;
	logic [63:0]        bits_q;

	logic               accept;
	logic               go_run;
	logic               quick;

	// slot generator
	sbf_pkg::slot_t     slot_s1;
	logic [2:0]         row_i;
	logic               side;
	logic [7:0]         row_byte;
	logic [5:0]         shift_l;
	logic [15:0]        pair;
	logic [7:0]         part_b;
	logic [7:0]         wall;
	logic signed [6:0]  yi;
	logic               off_screen;

	// memory stage
	logic [7:0]         frame_mem [sbf_pkg::NUM_ROWS];
	logic [sbf_pkg::NUM_ROWS-1:0] vld_q;
	logic [7:0]         rd_data_s2;
	logic               rd_vld_s2;
	logic               s2_vld_q;
	sbf_pkg::slot_t     slot_s2;
	logic [7:0]         rd_byte;
	logic [7:0]         wr_data;
	logic [7:0]         mirrored;
	logic               wr_en;
	logic               hit_now;
	logic               finish;
	logic               emit;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// request decode at accept
	always_comb begin
		go_run = 1'b0;
		quick  = 1'b0;
		unique case (req_type) inside
			sbf_pkg::REQ_BLIT, sbf_pkg::REQ_PIX_WR, sbf_pkg::REQ_PIX_RD,
			sbf_pkg::REQ_SCAN: go_run = 1'b1;
			default:           quick  = 1'b1;
		endcase
	end

	// request latch
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_type;
			op_q   <= op;
			x_q    <= x_pos;
			y_q    <= y_pos;
			bits_q <= sprite_bits;
		end
	end

	// slot generation: blit walks 16 parts (row, then left/right side)
	always_comb begin
		slot_s1    = '0;
		row_i      = cnt_q[3:1];
		side       = cnt_q[0];
		row_byte   = 8'(bits_q >> {~row_i, 3'b000});
		shift_l    = 6'(~x_q + 6'd1);
		pair       = x_q[5] ? ({row_byte, 8'h00} << shift_l)
		                    : ({row_byte, 8'h00} >> $unsigned(x_q));
		part_b     = side ? pair[7:0] : pair[15:8];
		wall       = side ? sbf_pkg::WALL_RIGHT : sbf_pkg::WALL_LEFT;
		yi         = {y_q[5], y_q} + {4'b0000, row_i};
		off_screen = (x_q > 6'sd15) || (x_q < -6'sd7) || (y_q > 6'sd15) || (y_q < -6'sd7);
		unique case (req_q) inside
			sbf_pkg::REQ_BLIT: begin
				slot_s1.last = (cnt_q == 5'(sbf_pkg::BLIT_SLOTS - 1));
				slot_s1.part = part_b;
				slot_s1.addr = {side, yi[3:0]};
				if (part_b != 8'h00) begin
					if (op_q == sbf_pkg::OP_TEST) begin
						if (yi < 7'sd0) begin
							slot_s1.imm = |(part_b & wall);
						end else if (yi > 7'sd15) begin
							slot_s1.imm = 1'b1;
						end else begin
							slot_s1.test = 1'b1;
						end
					end else if (!off_screen && yi >= 7'sd0 && yi <= 7'sd15
						&& op_q <= sbf_pkg::OP_CLR) begin
						slot_s1.wr = 1'b1;
					end
				end
			end
			sbf_pkg::REQ_PIX_WR, sbf_pkg::REQ_PIX_RD: begin
				slot_s1.last = 1'b1;
				slot_s1.part = sbf_pkg::PIX_MSB >> x_q[2:0];
				slot_s1.addr = {x_q[3], y_q[3:0]};
				if (x_q[5:4] == 2'b00 && y_q[5:4] == 2'b00) begin
					if (req_q == sbf_pkg::REQ_PIX_RD) begin
						slot_s1.test = 1'b1;
					end else if (op_q == sbf_pkg::OP_OR || op_q == sbf_pkg::OP_XOR
						|| op_q == sbf_pkg::OP_CLR) begin
						slot_s1.wr = 1'b1;
					end
				end
			end
			sbf_pkg::REQ_SCAN: begin
				slot_s1.scan = 1'b1;
				slot_s1.addr = cnt_q;
				slot_s1.last = (cnt_q == 5'(sbf_pkg::NUM_ROWS - 1));
			end
			default: slot_s1 = '0;
		endcase
	end

	// frame memory, registered read; slots of one blit never share an
	// address, so the write-back never meets a read of the same row
	always_ff @(posedge clk) begin
		rd_data_s2 <= frame_mem[slot_s1.addr];
		if (wr_en) begin
			frame_mem[slot_s2.addr] <= wr_data;
		end
	end

	// per-row written marks, an unwritten row reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s2 <= 1'b0;
		end else begin
			rd_vld_s2 <= vld_q[slot_s1.addr];
			if (accept && req_type == sbf_pkg::REQ_CLEAR) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[slot_s2.addr] <= 1'b1;
			end
		end
	end

	// read-modify-write and test stage
	always_comb begin
		rd_byte = rd_vld_s2 ? rd_data_s2 : 8'h00;
		case (op_q)
			sbf_pkg::OP_OR:  wr_data = rd_byte | slot_s2.part;
			sbf_pkg::OP_XOR: wr_data = rd_byte ^ slot_s2.part;
			sbf_pkg::OP_SET: wr_data = slot_s2.part;
			default:         wr_data = rd_byte & ~slot_s2.part;
		endcase
		for (int b = 0; b < 8; b++) begin
			mirrored[b] = rd_byte[7-b];
		end
	end

	assign wr_en   = s2_vld_q && slot_s2.wr;
	assign hit_now = slot_s2.imm || (slot_s2.test && (|(rd_byte & slot_s2.part)));
	assign finish  = s2_vld_q && (slot_s2.last || hit_now);
	assign emit    = s2_vld_q && (slot_s2.scan || finish);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			s2_vld_q <= 1'b0;
		end else begin
			s2_vld_q <= (state_q == S_RUN) && !finish;
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept && go_run) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					cnt_q <= cnt_q + 5'd1;
					if (finish) begin
						state_q <= S_IDLE;
					end else if (slot_s1.last) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// slot pipeline register
	always_ff @(posedge clk) begin
		slot_s2 <= slot_s1;
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe     <= 1'b0;
			hit_bit    <= 1'b0;
			chip_index <= '0;
			chip_row   <= '0;
			row_data   <= '0;
			last       <= 1'b0;
		end else begin
			strobe     <= (accept && quick) || emit;
			hit_bit    <= 1'b0;
			chip_index <= '0;
			chip_row   <= '0;
			row_data   <= '0;
			last       <= 1'b0;
			if (accept && quick) begin
				last <= 1'b1;
			end else if (emit) begin
				last <= finish;
				if (slot_s2.scan) begin
					// panels 1 and 2 swap chips, rows flip, bits mirror
					chip_index <= {slot_s2.addr[3], slot_s2.addr[4]};
					chip_row   <= ~slot_s2.addr[2:0];
					row_data   <= mirrored;
				end else begin
					hit_bit <= hit_now;
				end
			end
		end
	end

endmodule

`default_nettype wire

### test/sprite_blit_framebuffer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sprite_blit_framebuffer_tb
// Drives blits, pixel writes and queries, frame clears and scan-outs into
// the framebuffer, keeps its own copy of the 16x16 frame, and compares every
// result beat field by field with the beats this copy predicts.
// ----------------------------------------------------------------------------

module sprite_blit_framebuffer_tb;

	// request and op codes the block leaves undefined
	localparam logic [2:0] REQ_UNDEF_LO = 3'd5;
	localparam logic [2:0] REQ_UNDEF_HI = 3'd7;
	localparam logic [2:0] OP_UNDEF_LO  = 3'd5;
	localparam logic [2:0] OP_UNDEF_HI  = 3'd7;

	typedef struct packed {
		logic       hit;
		logic [1:0] chip;
		logic [2:0] crow;
		logic [7:0] data;
		logic       last_flag;
	} beat_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [2:0]         req_type = '0;
	logic [2:0]         op = '0;
	logic signed [5:0]  x_pos = '0;
	logic signed [5:0]  y_pos = '0;
	logic [63:0]        sprite_bits = '0;
	logic               busy;
	logic               strobe;
	logic               hit_bit;
	logic [1:0]         chip_index;
	logic [2:0]         chip_row;
	logic [7:0]         row_data;
	logic               last;

	logic [7:0] frame_model [sbf_pkg::NUM_ROWS];
	beat_t      pending_beats [$];
	int         errors = 0;
	int         burst_left = 1;

	sprite_blit_framebuffer dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.op(op),
		.x_pos(x_pos),
		.y_pos(y_pos),
		.sprite_bits(sprite_bits),
		.strobe(strobe),
		.hit_bit(hit_bit),
		.chip_index(chip_index),
		.chip_row(chip_row),
		.row_data(row_data),
		.last(last)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// frame model helpers
	function automatic logic [7:0] bit_reverse(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++)
			r[i] = b[7 - i];
		return r;
	endfunction

	function automatic void combine_row(input int idx, input logic [7:0] part,
			input logic [2:0] o);
		case (o)
			sbf_pkg::OP_OR:  frame_model[idx & 31] = frame_model[idx & 31] | part;
			sbf_pkg::OP_XOR: frame_model[idx & 31] = frame_model[idx & 31] ^ part;
			sbf_pkg::OP_SET: frame_model[idx & 31] = part;
			sbf_pkg::OP_CLR: frame_model[idx & 31] = frame_model[idx & 31] & ~part;
			default: ;
		endcase
	endfunction

	// rows above the top see the side walls, rows below the bottom always hit
	function automatic logic part_collides(input int yy, input int base,
			input logic [7:0] part, input logic [7:0] wall);
		if (yy < 0)
			return (part & wall) != 0;
		if (yy > 15)
			return 1'b1;
		return (frame_model[(base + yy) & 31] & part) != 0;
	endfunction

	function automatic logic blit_sprite(input logic [2:0] o, input int xi, input int yi,
			input logic [63:0] bits);
		logic [7:0] rowv, left, right;
		int yy;
		if (o != sbf_pkg::OP_TEST && (xi > 15 || xi < -7 || yi > 15 || yi < -7))
			return 1'b0;
		for (int i = 0; i < 8; i++) begin
			rowv = bits[63 - 8 * i -: 8];
			yy = yi + i;
			left = '0;
			right = '0;
			if (rowv == 0)
				continue;
			if (o != sbf_pkg::OP_TEST && (yy < 0 || yy > 15))
				continue;
			// split the row across the left and right panels
			if (xi >= 0 && xi < 8) begin
				left = rowv >> xi;
				right = (xi == 0) ? 8'h00 : 8'(rowv << (8 - xi));
			end else if (xi >= 8) begin
				right = (xi - 8 < 8) ? rowv >> (xi - 8) : 8'h00;
			end else begin
				left = (-xi < 8) ? 8'(rowv << (-xi)) : 8'h00;
			end
			if (left != 0) begin
				if (o == sbf_pkg::OP_TEST) begin
					if (part_collides(yy, 0, left, sbf_pkg::WALL_LEFT))
						return 1'b1;
				end else begin
					combine_row(yy, left, o);
				end
			end
			if (right != 0) begin
				if (o == sbf_pkg::OP_TEST) begin
					if (part_collides(yy, 16, right, sbf_pkg::WALL_RIGHT))
						return 1'b1;
				end else begin
					combine_row(16 + yy, right, o);
				end
			end
		end
		return 1'b0;
	endfunction

	// update the frame copy and queue the beats one request gives
	task automatic predict_request(input logic [2:0] rq, input logic [2:0] o,
			input logic signed [5:0] xv, input logic signed [5:0] yv, input logic [63:0] bits);
		int xi, yi, idx, k;
		logic hit;
		logic [7:0] mask;
		beat_t b;
		xi = xv;
		yi = yv;
		hit = 1'b0;
		if (rq == sbf_pkg::REQ_SCAN) begin
			k = 0;
			for (int p = 0; p < 4; p++) begin
				for (int r = 0; r < 8; r++) begin
					b.hit = 1'b0;
					b.chip = (p == 1) ? 2'd2 : (p == 2) ? 2'd1 : 2'(p);
					b.crow = 3'(7 - r);
					b.data = bit_reverse(frame_model[p * 8 + r]);
					b.last_flag = (k == 31);
					pending_beats.push_back(b);
					k++;
				end
			end
			return;
		end
		if (rq == sbf_pkg::REQ_BLIT) begin
			hit = blit_sprite(o, xi, yi, bits);
		end else if (rq == sbf_pkg::REQ_PIX_WR || rq == sbf_pkg::REQ_PIX_RD) begin
			if (xi >= 0 && xi <= 15 && yi >= 0 && yi <= 15) begin
				idx = (xi > 7 ? 16 : 0) + yi;
				mask = sbf_pkg::PIX_MSB >> (xi & 7);
				if (rq == sbf_pkg::REQ_PIX_RD)
					hit = (frame_model[idx] & mask) != 0;
				else if (o == sbf_pkg::OP_OR || o == sbf_pkg::OP_XOR
						|| o == sbf_pkg::OP_CLR)
					combine_row(idx, mask, o);
			end
		end else if (rq == sbf_pkg::REQ_CLEAR) begin
			foreach (frame_model[i])
				frame_model[i] = '0;
		end
		b = '{hit: hit, chip: 2'd0, crow: 3'd0, data: 8'd0, last_flag: 1'b1};
		pending_beats.push_back(b);
	endtask

	// one request beat; called at a rising edge, returns at one
	task automatic send_item(input logic [2:0] rq, input logic [2:0] o,
			input logic signed [5:0] xv, input logic signed [5:0] yv, input logic [63:0] bits);
		req_type <= rq;
		op <= o;
		x_pos <= xv;
		y_pos <= yv;
		sprite_bits <= bits;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_request(rq, o, xv, yv, bits);
		burst_left--;
		// end of burst: idle for a while
		if (burst_left <= 0) begin
			start <= 1'b0;
			repeat ($urandom_range(12, 1))
				@(posedge clk);
			burst_left = $urandom_range(20, 1);
		end
	endtask

	// result checker
	task automatic field_check(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		beat_t got, want;
		if (arst_n && strobe) begin
			got = '{hit_bit, chip_index, chip_row, row_data, last};
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected beat, expected none, got %p", $time, got);
				errors++;
			end else begin
				want = pending_beats.pop_front();
				field_check("hit_bit", want.hit, got.hit);
				field_check("chip_index", want.chip, got.chip);
				field_check("chip_row", want.crow, got.crow);
				field_check("row_data", want.data, got.data);
				field_check("last", want.last_flag, got.last_flag);
			end
		end
	end

	// directed: single pixels, edges of the frame and out-of-range coordinates
	task automatic test_pixel_access();
		send_item(sbf_pkg::REQ_PIX_WR, sbf_pkg::OP_OR, 0, 0, '0);
		send_item(sbf_pkg::REQ_PIX_WR, sbf_pkg::OP_OR, 15, 15, '1);
		send_item(sbf_pkg::REQ_PIX_WR, sbf_pkg::OP_XOR, 8, 7, '0);
		send_item(sbf_pkg::REQ_PIX_WR, sbf_pkg::OP_SET, 3, 3, '0);
		send_item(sbf_pkg::REQ_PIX_WR, sbf_pkg::OP_OR, 16, 2, '0);
		send_item(sbf_pkg::REQ_PIX_RD, sbf_pkg::OP_OR, 0, 0, '0);
		send_item(sbf_pkg::REQ_PIX_RD, sbf_pkg::OP_OR, 15, 15, '0);
		send_item(sbf_pkg::REQ_PIX_RD, sbf_pkg::OP_OR, -1, 3, '0);
		send_item(sbf_pkg::REQ_PIX_WR, sbf_pkg::OP_CLR, 0, 0, '0);
	endtask

	// directed: each writing blit op, empty rows, rows off the frame, undefined op
	task automatic test_blit_ops();
		send_item(sbf_pkg::REQ_BLIT, sbf_pkg::OP_OR, 3, 2, 64'hFF81_8181_8181_81FF);
		send_item(sbf_pkg::REQ_BLIT, sbf_pkg::OP_XOR, -7, -7, '1);
		send_item(sbf_pkg::REQ_BLIT, sbf_pkg::OP_SET, 12, 10, 64'h00A5_0000_3C00_0000);
		send_item(sbf_pkg::REQ_BLIT, sbf_pkg::OP_CLR, 0, 0, 64'hF0F0_0F0F_F0F0_0F0F);
		send_item(sbf_pkg::REQ_BLIT, OP_UNDEF_LO, 2, 2, '1);
		send_item(sbf_pkg::REQ_BLIT, sbf_pkg::OP_OR, 16, 0, '1);
	endtask

	// directed: side walls above the top, hits below the bottom, large shifts
	task automatic test_collision();
		send_item(sbf_pkg::REQ_BLIT, sbf_pkg::OP_TEST, 0, -3, 64'h8000_0000_0000_0000);
		send_item(sbf_pkg::REQ_BLIT, sbf_pkg::OP_TEST, 11, -2, 64'h8000_0000_0000_0000);
		send_item(sbf_pkg::REQ_BLIT, sbf_pkg::OP_TEST, 4, 14, '1);
		send_item(sbf_pkg::REQ_BLIT, sbf_pkg::OP_TEST, -16, 3, '1);
		send_item(sbf_pkg::REQ_BLIT, sbf_pkg::OP_TEST, 31, 3, '1);
		send_item(sbf_pkg::REQ_BLIT, sbf_pkg::OP_TEST, 3, 2, 64'h0000_0018_1800_0000);
	endtask

	// directed: scan-out, clear and undefined requests
	task automatic test_frame_requests();
		send_item(sbf_pkg::REQ_SCAN, sbf_pkg::OP_OR, 0, 0, '0);
		send_item(REQ_UNDEF_LO, sbf_pkg::OP_OR, 5, 5, '1);
		send_item(REQ_UNDEF_HI, sbf_pkg::OP_XOR, -1, -1, '1);
		send_item(sbf_pkg::REQ_CLEAR, sbf_pkg::OP_OR, 0, 0, '0);
		send_item(sbf_pkg::REQ_SCAN, sbf_pkg::OP_OR, 0, 0, '0);
	endtask

	function automatic logic signed [5:0] pick_coord(input int lo, input int hi);
		return 6'(int'($urandom_range(hi - lo)) + lo);
	endfunction

	// sprites with some empty rows, now and then all ones or a single row
	function automatic logic [63:0] pick_sprite();
		logic [63:0] bits;
		int kind;
		bits = {$urandom, $urandom};
		kind = $urandom_range(9);
		if (kind == 0)
			return '1;
		if (kind == 1)
			return bits & (64'hFF << (8 * $urandom_range(7)));
		for (int i = 0; i < 8; i++)
			if ($urandom_range(3) == 0)
				bits[8 * i +: 8] = '0;
		return bits;
	endfunction

	// random traffic: mostly on-screen blits, pixel access and queries
	task automatic test_random_traffic(input int count);
		int pct;
		logic [2:0] rq, o;
		logic signed [5:0] xv, yv;
		for (int n = 0; n < count; n++) begin
			pct = $urandom_range(99);
			o = 3'($urandom_range(3));
			if ($urandom_range(9) == 0) begin
				xv = pick_coord(-32, 31);
				yv = pick_coord(-32, 31);
			end else begin
				xv = pick_coord(-8, 16);
				yv = pick_coord(-8, 16);
			end
			if (pct < 45) begin
				rq = sbf_pkg::REQ_BLIT;
				if ($urandom_range(29) == 0)
					o = 3'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO));
			end else if (pct < 58) begin
				rq = sbf_pkg::REQ_BLIT;
				o = sbf_pkg::OP_TEST;
			end else if (pct < 75) begin
				rq = sbf_pkg::REQ_PIX_WR;
				if ($urandom_range(9) == 0)
					o = 3'($urandom_range(OP_UNDEF_HI, sbf_pkg::OP_TEST));
			end else if (pct < 91) begin
				rq = sbf_pkg::REQ_PIX_RD;
			end else if (pct < 95) begin
				rq = sbf_pkg::REQ_SCAN;
			end else if (pct < 97) begin
				rq = sbf_pkg::REQ_CLEAR;
			end else begin
				rq = 3'($urandom_range(REQ_UNDEF_HI, REQ_UNDEF_LO));
			end
			send_item(rq, o, xv, yv, pick_sprite());
		end
	endtask

	// main sequence
	initial begin
		int wait_cycles;
		foreach (frame_model[i])
			frame_model[i] = '0;
		burst_left = $urandom_range(20, 1);
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pixel_access();
		test_blit_ops();
		test_collision();
		test_frame_requests();
		test_random_traffic(434);
		start <= 1'b0;
		for (wait_cycles = 0; pending_beats.size() != 0 && wait_cycles < 4000; wait_cycles++)
			@(posedge clk);
		repeat (40)
			@(posedge clk);
		if (pending_beats.size() != 0) begin
			$display("%0t: expected %0d more beats, got none", $time, pending_beats.size());
			errors++;
		end
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
